[hdl/gbn_pkg.sv]
// Shared constants for the greedy box suppression block.
package gbn_pkg;
    localparam int          DEF_MAX_BOXES  = 64;
    localparam int          DEF_COORD_BITS = 16;
    localparam int          FIELD_BITS     = 16;
    localparam int          INDEX_BITS     = 6;
    localparam logic [15:0] THR_RESET      = 16'd19661;
endpackage

[hdl/greedy_box_nms_core.sv]
// Top level of the greedy box suppression block: load, search, suppress, emit.
// Boxes are taken one per cycle while loading; the box that carries last_box starts
// suppression, during which no box is taken. Each kept box costs one round: a score
// scan over all N stored boxes, the area state for the selected box, an overlap
// scan through the box RAM and the two-stage test, and an emit step. Both scans
// share the single read port of the box RAM. The user must write the threshold
// only while idle; the block itself does not enforce it.
module greedy_box_nms_core #(
    parameter int MAX_BOXES  = gbn_pkg::DEF_MAX_BOXES,
    parameter int COORD_BITS = gbn_pkg::DEF_COORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_left_x,
    input  logic [15:0] i_top_y,
    input  logic [15:0] i_right_x,
    input  logic [15:0] i_bottom_y,
    input  logic [15:0] i_box_score,
    input  logic        i_last_box,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_kept_left_x,
    output logic [15:0] o_kept_top_y,
    output logic [15:0] o_kept_right_x,
    output logic [15:0] o_kept_bottom_y,
    output logic [15:0] o_kept_score,
    output logic [5:0]  o_kept_index,
    output logic        o_final_result,
    output logic        o_overflow
);
    import gbn_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int BW = 4 * C;
    localparam int DW = BW + FIELD_BITS;
    localparam int EW = C + 1;
    localparam int AR = 2 * C + 2;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_AREA = 3'd2;
    localparam logic [2:0] S_SUPP = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]           r_state;
    logic [15:0]          r_thr;
    logic [CW-1:0]        r_cnt, r_addr, r_fin;
    logic [MAX_BOXES-1:0] r_live;
    logic                 r_drop;
    logic                 r_rd_vld;
    logic [AW-1:0]        r_rd_idx;
    logic                 r_found;
    logic [BW-1:0]        r_best_box;
    logic [15:0]          r_best_score;
    logic [AW-1:0]        r_best_idx;
    logic [AR-1:0]        r_tarea;

    logic                 r_ov;
    logic [BW-1:0]        r_o_box;
    logic [15:0]          r_o_score;
    logic [AW-1:0]        r_o_idx;
    logic                 r_o_fin, r_o_ovf;

    logic                 accept, store, issue, out_free, emit;
    logic [DW-1:0]        wdata, rdata;
    logic [BW-1:0]        rd_box;
    logic [15:0]          rd_score;
    logic                 iou_vld, iou_sup;
    logic [AW-1:0]        iou_idx;
    logic [EW-1:0]        tw, th;
    logic [MAX_BOXES-1:0] live_after;

    assign o_in_ready = (r_state == S_LOAD);
    assign accept     = i_in_valid && o_in_ready;
    assign store      = accept && (r_cnt < CW'(MAX_BOXES));
    assign issue      = ((r_state == S_SRCH) || (r_state == S_SUPP)) && (r_addr != r_cnt);
    assign out_free   = !r_ov || i_out_ready;
    assign emit       = (r_state == S_EMIT) && out_free;

    assign wdata = {i_box_score, i_bottom_y[C-1:0], i_right_x[C-1:0],
                    i_top_y[C-1:0], i_left_x[C-1:0]};
    assign rd_box   = rdata[BW-1:0];
    assign rd_score = rdata[DW-1:BW];

    gbn_ram #(.WIDTH(DW), .DEPTH(MAX_BOXES)) u_box_ram (
        .i_clk   (i_clk),
        .i_we    (store),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (rdata)
    );

    gbn_iou #(.COORD_BITS(C), .AW(AW)) u_iou (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_rd_vld && (r_state == S_SUPP)),
        .i_idx      (r_rd_idx),
        .i_top      (r_best_box),
        .i_top_area (r_tarea),
        .i_box      (rd_box),
        .i_thr      (r_thr),
        .o_valid    (iou_vld),
        .o_idx      (iou_idx),
        .o_suppress (iou_sup)
    );

    assign tw = (r_best_box[3*C-1:2*C] >= r_best_box[C-1:0]) ?
                ({1'b0, r_best_box[3*C-1:2*C]} - {1'b0, r_best_box[C-1:0]} + EW'(1)) : '0;
    assign th = (r_best_box[4*C-1:3*C] >= r_best_box[2*C-1:C]) ?
                ({1'b0, r_best_box[4*C-1:3*C]} - {1'b0, r_best_box[2*C-1:C]} + EW'(1)) : '0;

    assign live_after = r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_thr    <= THR_RESET;
            r_cnt    <= '0;
            r_addr   <= '0;
            r_fin    <= '0;
            r_live   <= '0;
            r_drop   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            r_rd_vld <= issue;
            if (issue) begin
                r_addr <= r_addr + CW'(1);
            end

            unique case (r_state)
                S_LOAD: begin
                    if (store) begin
                        r_live[r_cnt[AW-1:0]] <= 1'b1;
                        r_cnt                 <= r_cnt + CW'(1);
                    end else if (accept) begin
                        r_drop <= 1'b1;
                    end
                    if (accept && i_last_box) begin
                        r_state <= S_SRCH;
                        r_addr  <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_SRCH: begin
                    if (r_rd_vld && r_live[r_rd_idx] &&
                        (!r_found || (rd_score > r_best_score))) begin
                        r_found      <= 1'b1;
                        r_best_box   <= rd_box;
                        r_best_score <= rd_score;
                        r_best_idx   <= r_rd_idx;
                    end
                    if (!issue && !r_rd_vld) begin
                        r_state <= S_AREA;
                    end
                end
                S_AREA: begin
                    r_live[r_best_idx] <= 1'b0;
                    r_tarea            <= AR'(tw) * AR'(th);
                    r_addr             <= '0;
                    r_fin              <= '0;
                    r_state            <= S_SUPP;
                end
                S_SUPP: begin
                    if (iou_vld) begin
                        r_fin <= r_fin + CW'(1);
                        if (iou_sup) begin
                            r_live[iou_idx] <= 1'b0;
                        end
                    end
                    if (r_fin == r_cnt) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_o_box   <= r_best_box;
                        r_o_score <= r_best_score;
                        r_o_idx   <= r_best_idx;
                        r_o_fin   <= (live_after == '0);
                        r_o_ovf   <= r_drop;
                        if (live_after == '0) begin
                            r_cnt   <= '0;
                            r_drop  <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_addr  <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SRCH;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
        r_rd_idx <= r_addr[AW-1:0];
    end

    assign o_out_valid     = r_ov;
    assign o_kept_left_x   = 16'(r_o_box[C-1:0]);
    assign o_kept_top_y    = 16'(r_o_box[2*C-1:C]);
    assign o_kept_right_x  = 16'(r_o_box[3*C-1:2*C]);
    assign o_kept_bottom_y = 16'(r_o_box[4*C-1:3*C]);
    assign o_kept_score    = r_o_score;
    assign o_kept_index    = INDEX_BITS'(r_o_idx);
    assign o_final_result  = r_o_fin;
    assign o_overflow      = r_o_ovf;
endmodule

[hdl/gbn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/gbn_iou.sv]
// Two-stage overlap test of a stored box against the selected box.
module gbn_iou #(
    parameter int COORD_BITS = 16,
    parameter int AW         = 6
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [AW-1:0]             i_idx,
    input  logic [4*COORD_BITS-1:0]   i_top,
    input  logic [2*COORD_BITS+1:0]   i_top_area,
    input  logic [4*COORD_BITS-1:0]   i_box,
    input  logic [15:0]               i_thr,
    output logic                      o_valid,
    output logic [AW-1:0]             o_idx,
    output logic                      o_suppress
);
    localparam int C  = COORD_BITS;
    localparam int EW = C + 1;
    localparam int AR = 2 * C + 2;
    localparam int UW = 2 * C + 3;
    localparam int PW = 2 * C + 19;

    logic [C-1:0]  tl, tt, tr, tb, bl, bt, br, bb;
    logic [C-1:0]  ix1, iy1, ix2, iy2;
    logic [EW-1:0] iw, ih, bw, bh;
    logic [UW-1:0] uni;
    logic [PW-1:0] prod, lhs;

    logic          r_v1, r_v2;
    logic [AW-1:0] r_idx1, r_idx2;
    logic [AR-1:0] r_inter, r_areab;
    logic          r_sup;

    assign tl = i_top[C-1:0];
    assign tt = i_top[2*C-1:C];
    assign tr = i_top[3*C-1:2*C];
    assign tb = i_top[4*C-1:3*C];
    assign bl = i_box[C-1:0];
    assign bt = i_box[2*C-1:C];
    assign br = i_box[3*C-1:2*C];
    assign bb = i_box[4*C-1:3*C];

    assign ix1 = (tl > bl) ? tl : bl;
    assign iy1 = (tt > bt) ? tt : bt;
    assign ix2 = (tr < br) ? tr : br;
    assign iy2 = (tb < bb) ? tb : bb;

    // Inclusive extents, zero where the edges cross.
    assign iw = (ix2 >= ix1) ? ({1'b0, ix2} - {1'b0, ix1} + EW'(1)) : '0;
    assign ih = (iy2 >= iy1) ? ({1'b0, iy2} - {1'b0, iy1} + EW'(1)) : '0;
    assign bw = (br >= bl) ? ({1'b0, br} - {1'b0, bl} + EW'(1)) : '0;
    assign bh = (bb >= bt) ? ({1'b0, bb} - {1'b0, bt} + EW'(1)) : '0;

    assign uni  = UW'(i_top_area) + UW'(r_areab) - UW'(r_inter);
    assign prod = PW'(i_thr) * PW'(uni);
    assign lhs  = PW'({r_inter, 16'h0000});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_idx1  <= i_idx;
        r_inter <= AR'(iw) * AR'(ih);
        r_areab <= AR'(bw) * AR'(bh);
        r_idx2  <= r_idx1;
        r_sup   <= !(lhs < prod);
    end

    assign o_valid    = r_v2;
    assign o_idx      = r_idx2;
    assign o_suppress = r_sup;
endmodule
